FILE: rtl/poly_triangle_synth_voices_macros.svh
// Assertion macros shared by the checker of the synth voice core.
// Depends on nothing; include by bare file name.
`ifndef POLY_TRIANGLE_SYNTH_VOICES_MACROS_SVH
`define POLY_TRIANGLE_SYNTH_VOICES_MACROS_SVH

// Clocked property, switched off while reset is low.
`define PTSV_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds through reset.
`define PTSV_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/ptsv_pkg.sv
// Package for the polyphonic triangle synth core: command/status types and constants.
// No dependencies; imported by the controller, datapath, top level and checker.
`timescale 1ns / 1ps

package ptsv_pkg;

    // MIDI status high nibble
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;

    // 2^(s/12) in Q16, s = semitone within the octave
    localparam logic [16:0] SEMITONE_Q16 [12] = '{
        17'd65536,  17'd69433,  17'd73562,  17'd77936,
        17'd82570,  17'd87480,  17'd92682,  17'd98193,
        17'd104032, 17'd110218, 17'd116772, 17'd123715
    };

    // floor(y / 127) = (y * DIV127_MAGIC) >> DIV127_SHIFT, exact for y < 2^22
    localparam logic [22:0] DIV127_MAGIC = 23'd4227331;
    localparam int          DIV127_SHIFT = 29;
    localparam int          DIVY_W       = 22;
    localparam int          DIVP_W       = 45;

    localparam int TRI_W  = 16;
    localparam int PROD_W = 24;
    localparam int ACC_W  = 24;
    localparam int MIX_W  = 20;

    localparam logic signed [ACC_W-1:0] MIX_MAX = 24'sd524287;
    localparam logic signed [ACC_W-1:0] MIX_MIN = -24'sd524288;

    typedef struct packed {
        logic start;     // input transaction taken: latch fields, clear scan/accumulator
        logic issue;     // read the voice at the sweep address
        logic commit;    // end of a message sweep: claim the free voice if due
        logic out_load;  // move the saturated mix into the output register
    } t_cmd;

    typedef struct packed {
        logic op_tick;     // offered item is a sample tick
        logic note;        // offered item is a note on or note off
        logic pipe_empty;  // no voice in flight
    } t_stat;

endpackage

FILE: rtl/ptsv_ctrl.sv
// Controller for the synth core: sequences voice sweeps, commit and output hand-off.
// Depends on ptsv_pkg.
`timescale 1ns / 1ps

module ptsv_ctrl
    import ptsv_pkg::*;
#(
    parameter int VOICES = 16,
    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  t_stat            i_stat,
    output t_cmd             o_cmd,
    output logic [IDX_W-1:0] o_addr
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SWEEP  = 5'b00010,
        S_WAIT   = 5'b00100,
        S_COMMIT = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_vidx, n_vidx;
    logic             r_tick, n_tick;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_addr      = r_vidx;
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_vidx      = r_vidx;
        n_tick      = r_tick;
        n_out_valid = r_out_valid;
        o_cmd       = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.start = 1'b1;
                    n_tick      = i_stat.op_tick;
                    n_vidx      = '0;
                    if (i_stat.op_tick || i_stat.note) begin
                        n_state = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                o_cmd.issue = 1'b1;
                if (r_vidx == IDX_W'(VOICES - 1)) begin
                    n_state = S_WAIT;
                end else begin
                    n_vidx = r_vidx + 1'b1;
                end
            end
            S_WAIT: begin
                if (i_stat.pipe_empty) begin
                    n_state = r_tick ? S_FINISH : S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            S_FINISH: begin
                // output register must be free or emptying this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vidx      <= '0;
            r_tick      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vidx      <= n_vidx;
            r_tick      <= n_tick;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/ptsv_datapath.sv
// Datapath for the synth core: voice store, match/claim logic, phase and mix pipeline.
// Depends on ptsv_pkg; driven by ptsv_ctrl commands.
`timescale 1ns / 1ps

module ptsv_datapath
    import ptsv_pkg::*;
#(
    parameter int VOICES      = 16,
    parameter int SAMPLE_RATE = 48000,
    parameter int PHASE_BITS  = 24,
    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic [IDX_W-1:0]        i_addr,
    input  logic                    i_op,
    input  logic [7:0]              i_status_byte,
    input  logic [7:0]              i_key_byte,
    input  logic [7:0]              i_velocity_byte,
    output t_stat                   o_stat,
    output logic signed [MIX_W-1:0] o_mix_sample
);

    // pitch table, worked out at elaboration
    logic [PHASE_BITS-1:0] w_pitch [128];

    for (genvar k = 0; k < 128; k++) begin : g_pitch
        localparam logic [63:0] NUM =
            ((64'd440 * 64'(SEMITONE_Q16[k % 12])) << (k / 12)) << (PHASE_BITS - 16);
        localparam logic [63:0] DEN = 64'(SAMPLE_RATE) * 64'd16;
        localparam logic [63:0] INC = (NUM + DEN / 2) / DEN;
        assign w_pitch[k] = INC[PHASE_BITS-1:0];
    end

    // voice store
    logic [3:0]            r_mem_chan  [VOICES];
    logic [6:0]            r_mem_key   [VOICES];
    logic [PHASE_BITS-1:0] r_mem_phase [VOICES];
    logic [PHASE_BITS-1:0] r_mem_inc   [VOICES];
    logic [6:0]            r_mem_level [VOICES];
    logic [VOICES-1:0]     r_active;

    // latched message
    logic       r_tick;
    logic       r_on;
    logic [3:0] r_chan;
    logic [6:0] r_key;
    logic [6:0] r_vel;
    logic       r_dup;
    logic       r_found;
    logic [IDX_W-1:0] r_slot;

    // pipeline
    logic                  r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    logic [IDX_W-1:0]      r_s1_addr;
    logic                  r_s1_act;
    logic [3:0]            r_s1_chan;
    logic [6:0]            r_s1_key;
    logic [PHASE_BITS-1:0] r_s1_phase;
    logic [PHASE_BITS-1:0] r_s1_inc;
    logic [6:0]            r_s1_level;
    logic signed [TRI_W-1:0]  r_s2_tri;
    logic [6:0]               r_s2_level;
    logic signed [PROD_W-1:0] r_s3_prod;
    logic [DIVP_W-1:0]        r_s4_mul;
    logic                     r_s4_neg;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [MIX_W-1:0]  r_out;

    logic                    w_match;
    logic                    w_claim;
    logic [PHASE_BITS-1:0]   w_phase_nx;
    logic [PHASE_BITS:0]     w_twice;
    logic [PHASE_BITS:0]     w_full;
    logic [PHASE_BITS:0]     w_a;
    logic [16:0]             w_a_hi;
    logic signed [TRI_W-1:0] w_tri;
    logic signed [PROD_W-1:0] w_prod;
    logic                    w_neg;
    logic [PROD_W-1:0]       w_mag;
    logic [DIVY_W-1:0]       w_y;
    logic [15:0]             w_q;
    logic signed [ACC_W-1:0] w_term;
    logic signed [MIX_W-1:0] w_sat;
    logic [3:0]              w_kind;

    assign w_kind            = i_status_byte[7:4];
    assign o_stat.op_tick    = i_op;
    assign o_stat.note       = (w_kind == KIND_NOTE_ON) || (w_kind == KIND_NOTE_OFF);
    assign o_stat.pipe_empty = !(r_s1_v || r_s2_v || r_s3_v || r_s4_v);

    assign w_match = r_s1_act && (r_s1_chan == r_chan) && (r_s1_key == r_key);
    assign w_claim = r_on && !r_dup && r_found;

    // triangle of the advanced phase; a reaches 2^PHASE_BITS only at phase zero
    assign w_phase_nx = r_s1_phase + r_s1_inc;
    assign w_twice    = {w_phase_nx, 1'b0};
    assign w_full     = (PHASE_BITS + 1)'(1) << PHASE_BITS;
    assign w_a        = (w_twice >= w_full) ? (w_twice - w_full) : (w_full - w_twice);
    assign w_a_hi     = w_a[PHASE_BITS -: 17];
    assign w_tri      = w_a_hi[16] ? $signed(16'h7fff) : $signed(w_a_hi[15:0] ^ 16'h8000);

    assign w_prod = $signed(PROD_W'(r_s2_tri)) * $signed(PROD_W'({1'b0, r_s2_level}));

    // round to nearest on the magnitude, then divide by 127
    assign w_neg = r_s3_prod[PROD_W-1];
    assign w_mag = w_neg ? PROD_W'(-r_s3_prod) : PROD_W'(r_s3_prod);
    assign w_y   = w_mag[DIVY_W-1:0] + DIVY_W'(63);

    assign w_q    = r_s4_mul[DIV127_SHIFT +: 16];
    assign w_term = r_s4_neg ? -$signed(ACC_W'(w_q)) : $signed(ACC_W'(w_q));

    always_comb begin
        priority if (r_acc > MIX_MAX) begin
            w_sat = MIX_MAX[MIX_W-1:0];
        end else if (r_acc < MIX_MIN) begin
            w_sat = MIX_MIN[MIX_W-1:0];
        end else begin
            w_sat = r_acc[MIX_W-1:0];
        end
    end

    assign o_mix_sample = r_out;

    // control: valid flags and voice active bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_s3_v   <= 1'b0;
            r_s4_v   <= 1'b0;
            r_active <= '0;
        end else begin
            r_s1_v <= i_cmd.issue;
            r_s2_v <= r_s1_v && r_tick && r_s1_act;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            if (r_s1_v && !r_tick && !r_on && w_match) begin
                r_active[r_s1_addr] <= 1'b0;
            end
            if (i_cmd.commit && w_claim) begin
                r_active[r_slot] <= 1'b1;
            end
        end
    end

    // store reads and writes
    always_ff @(posedge i_clk) begin
        r_s1_addr  <= i_addr;
        r_s1_act   <= r_active[i_addr];
        r_s1_chan  <= r_mem_chan[i_addr];
        r_s1_key   <= r_mem_key[i_addr];
        r_s1_phase <= r_mem_phase[i_addr];
        r_s1_inc   <= r_mem_inc[i_addr];
        r_s1_level <= r_mem_level[i_addr];

        priority if (i_cmd.commit && w_claim) begin
            r_mem_chan[r_slot]  <= r_chan;
            r_mem_key[r_slot]   <= r_key;
            r_mem_phase[r_slot] <= '0;
            r_mem_inc[r_slot]   <= w_pitch[r_key];
            r_mem_level[r_slot] <= r_vel;
        end else if (r_s1_v && r_tick && r_s1_act) begin
            r_mem_phase[r_s1_addr] <= w_phase_nx;
        end
    end

    // message latch, scan results, mix pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_tick  <= i_op;
            r_on    <= (w_kind == KIND_NOTE_ON);
            r_chan  <= i_status_byte[3:0];
            r_key   <= i_key_byte[6:0];
            r_vel   <= i_velocity_byte[6:0];
            r_dup   <= 1'b0;
            r_found <= 1'b0;
        end else if (r_s1_v && !r_tick) begin
            if (w_match) begin
                r_dup <= 1'b1;
            end else if (!r_s1_act && !r_found) begin
                r_found <= 1'b1;
                r_slot  <= r_s1_addr;
            end
        end

        r_s2_tri   <= w_tri;
        r_s2_level <= r_s1_level;
        r_s3_prod  <= w_prod;
        r_s4_mul   <= DIVP_W'(w_y) * DIVP_W'(DIV127_MAGIC);
        r_s4_neg   <= w_neg;

        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_s4_v) begin
            r_acc <= r_acc + w_term;
        end

        if (i_cmd.out_load) begin
            r_out <= w_sat;
        end
    end

endmodule

FILE: rtl/poly_triangle_synth_voices.sv
// Polyphonic triangle synth core, top level: controller plus datapath.
// Depends on ptsv_pkg, ptsv_ctrl and ptsv_datapath.
//
// Input channel (i_in_valid / o_in_ready): one transaction is either a MIDI
// message (i_op = 0; note on 0x9n, note off 0x8n, anything else ignored) or a
// sample tick (i_op = 1). Output channel (o_out_valid / i_out_ready) carries
// one signed 20-bit mixed sample per tick and nothing for messages.
// Timing: a note message sweeps every voice once before the input is ready
// again; an ignored message leaves the input ready. A tick sweeps the voices
// through a five-stage phase/triangle/scale pipeline, and o_out_valid rises
// once the pipeline has drained, sooner when the last voices are idle. The
// sweep of the single-port voice store, one voice per cycle, sets the rate.
// Items are taken one at a time; a message is accepted while a sample still
// waits in the output register, a tick finishes its sweep and holds its mix
// until that register is free.
// Reset: all voices inactive, both channels empty. The voice store itself is
// not cleared; entries are only used once a note on has claimed them.
`timescale 1ns / 1ps

module poly_triangle_synth_voices
    import ptsv_pkg::*;
#(
    parameter int VOICES      = 16,
    parameter int SAMPLE_RATE = 48000,
    parameter int PHASE_BITS  = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_op,
    input  logic [7:0]              i_status_byte,
    input  logic [7:0]              i_key_byte,
    input  logic [7:0]              i_velocity_byte,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [MIX_W-1:0] o_mix_sample
);

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    t_cmd             w_cmd;
    t_stat            w_stat;
    logic [IDX_W-1:0] w_addr;

    ptsv_ctrl #(
        .VOICES (VOICES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_addr      (w_addr)
    );

    ptsv_datapath #(
        .VOICES      (VOICES),
        .SAMPLE_RATE (SAMPLE_RATE),
        .PHASE_BITS  (PHASE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_addr          (w_addr),
        .i_op            (i_op),
        .i_status_byte   (i_status_byte),
        .i_key_byte      (i_key_byte),
        .i_velocity_byte (i_velocity_byte),
        .o_stat          (w_stat),
        .o_mix_sample    (o_mix_sample)
    );

endmodule

FILE: rtl/ptsv_checker.sv
// Port-level checker for the synth core, bound to the top level.
// Depends on poly_triangle_synth_voices_macros.svh and ptsv_pkg.
`timescale 1ns / 1ps
`include "poly_triangle_synth_voices_macros.svh"

module ptsv_checker
    import ptsv_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic                    i_op,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic signed [MIX_W-1:0] o_mix_sample
);

    `PTSV_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "output transaction dropped while stalled")
    `PTSV_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_mix_sample), "sample changed while stalled")
    `PTSV_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "output valid straight after reset")
    // a message never produces a sample
    `PTSV_ASSERT(a_msg_no_out, i_clk, i_rst_n, i_in_valid && o_in_ready && !i_op && !o_out_valid |=> !o_out_valid, "message transaction raised output valid")
    // a tick always sweeps the voices before the next transaction
    `PTSV_ASSERT(a_tick_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && i_op |=> !o_in_ready, "input ready straight after a tick")

endmodule

bind poly_triangle_synth_voices ptsv_checker u_ptsv_checker (.*);
